// ===== rtl/core/oam_pkg.sv =====
// oam_pkg: shared constants, action codes and control/status structs
// used by the oam dma controller, datapath and top level; no dependencies
`default_nettype none

package oam_pkg;

    // parameter defaults
    localparam int unsigned DEF_TRANSFER_LEN    = 160;
    localparam int unsigned DEF_CYCLES_PER_BYTE = 4;
    localparam int unsigned DEF_START_DELAY     = 8;

    // fixed sizes
    localparam int unsigned MAX_RESULTS = 64;
    localparam int unsigned CNT_W       = 7;
    localparam int unsigned ACCUM_W     = 9;
    localparam int unsigned DELAY_W     = 4;
    localparam logic [ACCUM_W-1:0] ACCUM_MAX = 9'd511;
    localparam logic [7:0]  PAGE_RST = 8'hFF;
    localparam logic [15:0] OAM_LO   = 16'hFE00;
    localparam logic [15:0] OAM_HI   = 16'hFE9F;

    // action codes
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_CHECK = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic add;
        logic copy;
        logic seg_end;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic tick_run;
        logic can_copy;
        logic start_after;
        logic rem_zero;
        logic out_free;
        logic last_emit;
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/core/oam_ctrl.sv =====
// oam_ctrl: sequencing state machine of the oam dma engine
// depends on oam_pkg (t_cmd, t_sts)
`default_nettype none

module oam_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire oam_pkg::t_sts i_sts,
    output logic               o_ready,
    output oam_pkg::t_cmd      o_cmd
);
    import oam_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADD,
        S_COPY,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = i_sts.tick_run ? S_ADD : S_EMIT;
                end
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = S_COPY;
            end
            S_COPY: begin
                if (i_sts.can_copy) begin
                    o_cmd.copy = 1'b1;
                end else begin
                    o_cmd.seg_end = 1'b1;
                    // second segment only when the new transfer starts with cycles left
                    n_state = (i_sts.start_after && !i_sts.rem_zero) ? S_ADD : S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.last_emit) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/oam_dp.sv =====
// oam_dp: transfer state, cycle accounting, copy counting and output register
// depends on oam_pkg; driven by commands from oam_ctrl
`default_nettype none

module oam_dp #(
    parameter int unsigned TRANSFER_LEN    = oam_pkg::DEF_TRANSFER_LEN,
    parameter int unsigned CYCLES_PER_BYTE = oam_pkg::DEF_CYCLES_PER_BYTE,
    parameter int unsigned START_DELAY     = oam_pkg::DEF_START_DELAY
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire oam_pkg::t_cmd i_cmd,
    output oam_pkg::t_sts      o_sts,
    input  wire logic [1:0]    i_action,
    input  wire logic [7:0]    i_cycles,
    input  wire logic [7:0]    i_page,
    input  wire logic [15:0]   i_addr,
    input  wire logic          i_ready,
    output logic               o_valid,
    output logic               o_copy_valid,
    output logic [15:0]        o_src_addr,
    output logic [7:0]         o_oam_index,
    output logic               o_last,
    output logic               o_dma_active,
    output logic               o_oam_blocked,
    output logic [7:0]         o_dma_reg
);
    import oam_pkg::*;

    localparam int unsigned PW = $clog2(TRANSFER_LEN + 1);

    // transfer state
    logic               r_active;
    logic               r_pending;
    logic [DELAY_W-1:0] r_delay;
    logic [7:0]         r_pending_page;
    logic [7:0]         r_source_page;
    logic [PW-1:0]      r_progress;
    logic [ACCUM_W-1:0] r_accum;
    logic [7:0]         r_page_reg;

    // per-item work registers
    logic [7:0]         r_rem;
    logic               r_start;
    logic               r_seg;
    logic               r_blocked;
    logic [7:0]         r_sp0;
    logic [PW-1:0]      r_ss0;
    logic [CNT_W-1:0]   r_n0;
    logic [CNT_W-1:0]   r_total;
    logic [CNT_W-1:0]   r_k;

    // output register
    logic        r_out_valid;
    logic        r_out_copy;
    logic [15:0] r_out_src;
    logic [7:0]  r_out_idx;
    logic        r_out_last;
    logic        r_out_active;
    logic        r_out_blocked;
    logic [7:0]  r_out_reg;

    logic [7:0]         delay8;
    logic               delay_hit;
    logic [7:0]         step;
    logic [ACCUM_W:0]   sum;
    logic               can_copy;
    logic               out_free;
    logic [CNT_W-1:0]   k_next;
    logic               last_emit;
    logic               in_seg0;
    logic [7:0]         e_prog;
    logic               in_oam;

    assign delay8    = 8'(r_delay);
    assign delay_hit = r_pending && !(r_rem < delay8);
    assign step      = (r_pending && (r_rem >= delay8)) ? delay8 : r_rem;
    assign sum       = (ACCUM_W+1)'(r_accum) + (ACCUM_W+1)'(step);

    assign can_copy = r_active && (r_accum >= ACCUM_W'(CYCLES_PER_BYTE))
                    && (r_progress < PW'(TRANSFER_LEN))
                    && (r_total < CNT_W'(MAX_RESULTS));

    assign out_free  = !r_out_valid || i_ready;
    assign k_next    = r_k + CNT_W'(1);
    assign last_emit = (k_next >= r_total);
    assign in_seg0   = (r_k < r_n0);
    assign e_prog    = in_seg0 ? (8'(r_ss0) + 8'(r_k)) : 8'(r_k - r_n0);
    assign in_oam    = (i_addr >= OAM_LO) && (i_addr <= OAM_HI);

    always_comb begin
        o_sts.tick_run    = (i_action == ACT_TICK) && (i_cycles != 8'd0);
        o_sts.can_copy    = can_copy;
        o_sts.start_after = r_start;
        o_sts.rem_zero    = (r_rem == 8'd0);
        o_sts.out_free    = out_free;
        o_sts.last_emit   = last_emit;
    end

    // transfer state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active       <= 1'b0;
            r_pending      <= 1'b0;
            r_delay        <= '0;
            r_pending_page <= 8'd0;
            r_source_page  <= 8'd0;
            r_progress     <= '0;
            r_accum        <= '0;
            r_page_reg     <= PAGE_RST;
            r_start        <= 1'b0;
            r_seg          <= 1'b0;
            r_n0           <= '0;
            r_total        <= '0;
            r_k            <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_seg   <= 1'b0;
                r_start <= 1'b0;
                r_n0    <= '0;
                r_total <= '0;
                r_k     <= '0;
                if (i_action == ACT_WRITE) begin
                    r_page_reg     <= i_page;
                    r_pending      <= 1'b1;
                    r_pending_page <= i_page;
                    r_delay        <= DELAY_W'(START_DELAY);
                end
            end
            if (i_cmd.add) begin
                r_start <= delay_hit;
                if (r_pending) begin
                    r_delay <= r_delay - DELAY_W'(step);
                end
                if (r_active) begin
                    r_accum <= (sum > (ACCUM_W+1)'(ACCUM_MAX)) ? ACCUM_MAX : sum[ACCUM_W-1:0];
                end
            end
            if (i_cmd.copy) begin
                r_progress <= r_progress + PW'(1);
                r_accum    <= r_accum - ACCUM_W'(CYCLES_PER_BYTE);
                r_total    <= r_total + CNT_W'(1);
                if (!r_seg) begin
                    r_n0 <= r_n0 + CNT_W'(1);
                end
            end
            if (i_cmd.seg_end) begin
                if (r_progress >= PW'(TRANSFER_LEN)) begin
                    r_active <= 1'b0;
                end
                if (r_start) begin
                    r_source_page <= r_pending_page;
                    r_progress    <= '0;
                    r_accum       <= '0;
                    r_active      <= 1'b1;
                    r_pending     <= 1'b0;
                    r_seg         <= 1'b1;
                end
            end
            if (i_cmd.emit) begin
                r_k         <= k_next;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rem     <= i_cycles;
            r_blocked <= (i_action == ACT_CHECK) && r_active && in_oam;
        end
        if (i_cmd.add) begin
            r_rem <= r_rem - step;
            if (!r_seg) begin
                r_sp0 <= r_source_page;
                r_ss0 <= r_progress;
            end
        end
        if (i_cmd.emit) begin
            r_out_copy    <= (r_total != '0);
            r_out_src     <= (r_total != '0)
                           ? {(in_seg0 ? r_sp0 : r_source_page), e_prog} : 16'd0;
            r_out_idx     <= (r_total != '0) ? e_prog : 8'd0;
            r_out_last    <= last_emit;
            r_out_active  <= r_active;
            r_out_blocked <= (r_total == '0) ? r_blocked : 1'b0;
            r_out_reg     <= r_page_reg;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_copy_valid  = r_out_copy;
    assign o_src_addr    = r_out_src;
    assign o_oam_index   = r_out_idx;
    assign o_last        = r_out_last;
    assign o_dma_active  = r_out_active;
    assign o_oam_blocked = r_out_blocked;
    assign o_dma_reg     = r_out_reg;

endmodule

`default_nettype wire

// ===== rtl/core/oam_dma_engine.sv =====
// oam_dma_engine: top level, a write, a check, an unknown action or a zero-cycle tick is
// accepted and gives one result; a tick that copies n bytes runs an add step and a copy
// scan per segment, then gives max(n, 1) results: the scan of the shared copy counter
// (one byte a cycle), then one result a cycle out of the output register when it is free
// one item in work at a time; the next item is taken while the last result still waits
// reset is synchronous active low: no transfer, no pending start, dma register reads 0xff
`default_nettype none

module oam_dma_engine #(
    parameter int unsigned TRANSFER_LEN    = oam_pkg::DEF_TRANSFER_LEN,
    parameter int unsigned CYCLES_PER_BYTE = oam_pkg::DEF_CYCLES_PER_BYTE,
    parameter int unsigned START_DELAY     = oam_pkg::DEF_START_DELAY
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input item channel
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_action,
    input  wire logic [7:0]  i_cycles,
    input  wire logic [7:0]  i_page,
    input  wire logic [15:0] i_addr,
    // result channel
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_copy_valid,
    output logic [15:0]      o_src_addr,
    output logic [7:0]       o_oam_index,
    output logic             o_last,
    output logic             o_dma_active,
    output logic             o_oam_blocked,
    output logic [7:0]       o_dma_reg
);
    import oam_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencer: idle -> add (spend cycles of one segment) -> copy scan -> emit
    // a tick has at most two segments: the old transfer up to the end of the start
    // delay, then the new transfer with the cycles left over
    oam_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_ready (o_ready),
        .o_cmd   (cmd)
    );

    // datapath: the whole tick is resolved first so that the final transfer state
    // is known on every result, then copy commands are rebuilt from segment marks
    oam_dp #(
        .TRANSFER_LEN    (TRANSFER_LEN),
        .CYCLES_PER_BYTE (CYCLES_PER_BYTE),
        .START_DELAY     (START_DELAY)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_action      (i_action),
        .i_cycles      (i_cycles),
        .i_page        (i_page),
        .i_addr        (i_addr),
        .i_ready       (i_ready),
        .o_valid       (o_valid),
        .o_copy_valid  (o_copy_valid),
        .o_src_addr    (o_src_addr),
        .o_oam_index   (o_oam_index),
        .o_last        (o_last),
        .o_dma_active  (o_dma_active),
        .o_oam_blocked (o_oam_blocked),
        .o_dma_reg     (o_dma_reg)
    );

endmodule

`default_nettype wire

// ===== tb/tb_oam_dma_engine.sv =====
// tb_oam_dma_engine: self-checking testbench for the sprite-memory dma engine,
// directed and random transfers scored against an in-bench model of the block
// depends on oam_pkg and oam_dma_engine
`default_nettype none

module tb_oam_dma_engine;
    timeunit 1ns;
    timeprecision 1ps;

    import oam_pkg::*;

    // code that the block decodes as no operation
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam int unsigned XFER_LEN   = DEF_TRANSFER_LEN;
    localparam int unsigned BYTE_CYC   = DEF_CYCLES_PER_BYTE;
    localparam int unsigned START_WAIT = DEF_START_DELAY;

    // cycles to wait after the last expected result
    localparam int unsigned SETTLE_CYC = 400;
    // hard stop, several times the slowest correct run
    localparam longint unsigned RUN_LIMIT_NS = 64'd5_000_000;

    // one result as it leaves the block
    typedef struct {
        logic        copy_valid;
        logic [15:0] src_addr;
        logic [7:0]  oam_index;
        logic        last;
        logic        dma_active;
        logic        oam_blocked;
        logic [7:0]  dma_reg;
    } dma_result_t;

    // clock, reset and the two channels, all known from time zero
    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        i_valid  = 1'b0;
    logic [1:0]  i_action = ACT_TICK;
    logic [7:0]  i_cycles = 8'd0;
    logic [7:0]  i_page   = 8'd0;
    logic [15:0] i_addr   = 16'd0;
    logic        i_ready  = 1'b0;

    logic        o_ready;
    logic        o_valid;
    logic        o_copy_valid;
    logic [15:0] o_src_addr;
    logic [7:0]  o_oam_index;
    logic        o_last;
    logic        o_dma_active;
    logic        o_oam_blocked;
    logic [7:0]  o_dma_reg;

    oam_dma_engine DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_action      (i_action),
        .i_cycles      (i_cycles),
        .i_page        (i_page),
        .i_addr        (i_addr),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_copy_valid  (o_copy_valid),
        .o_src_addr    (o_src_addr),
        .o_oam_index   (o_oam_index),
        .o_last        (o_last),
        .o_dma_active  (o_dma_active),
        .o_oam_blocked (o_oam_blocked),
        .o_dma_reg     (o_dma_reg)
    );

    // --------------------------------------------------------------
    // mirror of the engine state
    // --------------------------------------------------------------
    logic       xfer_active;
    logic       start_armed;
    logic [3:0] start_wait_left;
    logic [7:0] armed_page;
    logic [7:0] xfer_page;
    logic [8:0] xfer_pos;       // one bit wider than the oam index
    logic [8:0] cyc_bank;       // saturating cycle accumulator
    logic [7:0] page_readback;

    dma_result_t expected_results[$];

    // bookkeeping
    bit quiet = 1'b0;           // no idling on either side when set
    int errors       = 0;
    int items_sent   = 0;
    int results_seen = 0;
    int copies_seen  = 0;
    int blocked_seen = 0;

    // --------------------------------------------------------------
    // model of the engine
    // --------------------------------------------------------------

    // spend cycles on the running transfer, one copy per byte period
    function automatic void spend_cycles(input int unsigned step, ref dma_result_t res[$]);
        logic [9:0]  sum;
        dma_result_t r;
        if (!xfer_active || step == 0)
            return;
        sum = {1'b0, cyc_bank} + step[9:0];
        cyc_bank = (sum > {1'b0, ACCUM_MAX}) ? ACCUM_MAX : sum[8:0];
        // stalls once a tick has produced its maximum number of copies
        while (cyc_bank >= BYTE_CYC && xfer_pos < XFER_LEN && res.size() < MAX_RESULTS) begin
            r.copy_valid  = 1'b1;
            r.src_addr    = {xfer_page, 8'h00} + {7'd0, xfer_pos};
            r.oam_index   = xfer_pos[7:0];
            r.last        = 1'b0;
            r.dma_active  = 1'b0;
            r.oam_blocked = 1'b0;
            r.dma_reg     = 8'h00;
            res.push_back(r);
            xfer_pos = xfer_pos + 9'd1;
            cyc_bank = cyc_bank - BYTE_CYC[8:0];
        end
        if (xfer_pos >= XFER_LEN)
            xfer_active = 1'b0;
    endfunction

    // work out every result one accepted item causes
    function automatic void predict_transfer(input logic [1:0] act, input logic [7:0] cyc,
                                             input logic [7:0] pg, input logic [15:0] ad);
        dma_result_t    res[$];
        dma_result_t    r;
        int unsigned    rem;
        int unsigned    step;
        logic           blocked;
        blocked = 1'b0;
        case (act)
            ACT_TICK: begin
                rem = cyc;
                while (rem > 0) begin
                    if (start_armed && start_wait_left > 0) begin
                        // old transfer keeps going until the start delay runs out
                        step = (rem < start_wait_left) ? rem : start_wait_left;
                        spend_cycles(step, res);
                        rem = rem - step;
                        start_wait_left = start_wait_left - step[3:0];
                        if (start_wait_left == 0) begin
                            xfer_page   = armed_page;
                            xfer_pos    = 9'd0;
                            cyc_bank    = 9'd0;
                            xfer_active = 1'b1;
                            start_armed = 1'b0;
                        end
                    end else begin
                        spend_cycles(rem, res);
                        rem = 0;
                    end
                end
            end
            ACT_WRITE: begin
                page_readback   = pg;
                start_armed     = 1'b1;
                armed_page      = pg;
                start_wait_left = START_WAIT[3:0];
            end
            ACT_CHECK: begin
                blocked = xfer_active && ad >= OAM_LO && ad <= OAM_HI;
            end
            default: ;
        endcase

        // items that copy nothing still give one status result
        if (res.size() == 0) begin
            r.copy_valid  = 1'b0;
            r.src_addr    = 16'd0;
            r.oam_index   = 8'd0;
            r.oam_blocked = blocked;
            res.push_back(r);
        end
        foreach (res[k]) begin
            res[k].last       = (k == res.size() - 1);
            res[k].dma_active = xfer_active;
            if (res[k].copy_valid)
                res[k].oam_blocked = 1'b0;
            res[k].dma_reg = page_readback;
            expected_results.push_back(res[k]);
        end
    endfunction

    // --------------------------------------------------------------
    // clock and watchdog
    // --------------------------------------------------------------
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("%0t: timeout, %0d results still expected", $time, expected_results.size());
        $display("TEST FAILED");
        $finish;
    end

    // --------------------------------------------------------------
    // sending side
    // --------------------------------------------------------------

    // present one item, hold it until the transfer, then score it in the model
    task automatic send_item(input logic [1:0] act, input logic [7:0] cyc,
                             input logic [7:0] pg, input logic [15:0] ad);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_action <= act;
        i_cycles <= cyc;
        i_page   <= pg;
        i_addr   <= ad;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_transfer(act, cyc, pg, ad);
        items_sent++;
    endtask

    // unused fields carry random values so the block must ignore them
    task automatic do_tick(input logic [7:0] cyc);
        send_item(ACT_TICK, cyc, 8'($urandom), 16'($urandom));
    endtask

    task automatic do_write(input logic [7:0] pg);
        send_item(ACT_WRITE, 8'($urandom), pg, 16'($urandom));
    endtask

    task automatic do_check(input logic [15:0] ad);
        send_item(ACT_CHECK, 8'($urandom), 8'($urandom), ad);
    endtask

    // addresses around and inside the sprite window
    function automatic logic [15:0] pick_addr();
        case ($urandom_range(0, 5))
            0:       return OAM_LO;
            1:       return OAM_HI;
            2:       return OAM_LO - 16'd1;
            3:       return OAM_HI + 16'd1;
            4:       return 16'($urandom);
            default: return OAM_LO + 16'($urandom_range(0, 159));
        endcase
    endfunction

    // mostly short ticks, some long ones that hit the per-tick copy limit
    function automatic logic [7:0] pick_cycles();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return 8'($urandom_range(1, 48));
            6, 7:             return 8'($urandom_range(0, 255));
            8:                return 8'd255;
            default:          return 8'($urandom_range(1, 8));
        endcase
    endfunction

    // --------------------------------------------------------------
    // receiving side: random stall bursts and the scoreboard
    // --------------------------------------------------------------
    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    initial begin
        int          stall_left;
        dma_result_t exp_r;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                results_seen++;
                if (o_copy_valid === 1'b1)
                    copies_seen++;
                if (o_oam_blocked === 1'b1)
                    blocked_seen++;
                if (expected_results.size() == 0) begin
                    $display("%0t: result with nothing expected, expected none actual src %0h",
                             $time, o_src_addr);
                    errors++;
                end else begin
                    exp_r = expected_results.pop_front();
                    check_field("copy_valid",  16'(exp_r.copy_valid),  16'(o_copy_valid));
                    check_field("src_addr",    exp_r.src_addr,         o_src_addr);
                    check_field("oam_index",   16'(exp_r.oam_index),   16'(o_oam_index));
                    check_field("last",        16'(exp_r.last),        16'(o_last));
                    check_field("dma_active",  16'(exp_r.dma_active),  16'(o_dma_active));
                    check_field("oam_blocked", 16'(exp_r.oam_blocked), 16'(o_oam_blocked));
                    check_field("dma_reg",     16'(exp_r.dma_reg),     16'(o_dma_reg));
                end
            end
            // ready handling, one assignment per edge
            if (quiet)
                stall_left = 0;
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else if (!quiet && i_rst_n && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 5) - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // --------------------------------------------------------------
    // tests
    // --------------------------------------------------------------

    // nothing running: status results only, idle ticks must not bank cycles
    task automatic test_idle_status();
        do_check(OAM_LO);
        send_item(ACT_UNUSED, 8'hFF, 8'hFF, 16'hFFFF);
        do_tick(8'd0);
        do_tick(8'd255);
        do_check(16'hFFFF);
    endtask

    // start delay split over two ticks, then window edges while running
    task automatic test_start_delay();
        do_write(8'h00);
        do_tick(8'd3);
        do_check(OAM_LO);
        do_tick(8'd5);
        do_check(OAM_LO);
        do_check(OAM_HI);
        do_check(OAM_LO - 16'd1);
        do_check(OAM_HI + 16'd1);
    endtask

    // run to the end, with the per-tick copy limit reached on the way
    task automatic test_full_transfer();
        do_tick(8'd255);
        do_tick(8'd255);
        do_tick(8'd255);
        do_tick(8'd4);
        do_check(OAM_LO + 16'd10);
    endtask

    // rewrite during the delay, and a new page while the old one still copies
    task automatic test_restart();
        do_write(8'hFF);
        do_tick(8'd6);
        do_write(8'h12);
        do_tick(8'd7);
        do_tick(8'd1);
        do_tick(8'd17);
        do_write(8'h80);
        do_tick(8'd8);
        do_tick(8'd3);
        do_tick(8'd0);
        do_check(OAM_HI);
    endtask

    // mostly well-formed write-then-tick sequences, some noise
    task automatic test_random_traffic(input int count);
        int n;
        int len;
        n = 0;
        while (n < count) begin
            if ($urandom_range(0, 4) != 0) begin
                do_write(8'($urandom));
                n++;
                len = $urandom_range(4, 14);
                repeat (len) begin
                    case ($urandom_range(0, 9))
                        0, 1:    do_check(pick_addr());
                        2: begin
                            if ($urandom_range(0, 2) == 0)
                                do_write(8'($urandom));
                            else
                                do_tick(pick_cycles());
                        end
                        default: do_tick(pick_cycles());
                    endcase
                    n++;
                end
            end else begin
                case ($urandom_range(0, 2))
                    0:       send_item(ACT_UNUSED, 8'($urandom), 8'($urandom), 16'($urandom));
                    1:       do_check(16'($urandom));
                    default: do_tick(8'($urandom));
                endcase
                n++;
            end
        end
    endtask

    // back-to-back transfers with no idling, one transfer run to completion
    task automatic test_full_rate();
        quiet = 1'b1;
        do_write(8'($urandom));
        do_tick(8'd8);
        repeat (3) do_tick(8'd255);
        do_check(OAM_LO);
        do_write(8'($urandom));
        repeat (6) do_tick(pick_cycles());
        do_check(pick_addr());
        i_valid <= 1'b0;
    endtask

    // --------------------------------------------------------------
    // main sequence
    // --------------------------------------------------------------
    initial begin
        xfer_active     = 1'b0;
        start_armed     = 1'b0;
        start_wait_left = 4'd0;
        armed_page      = 8'd0;
        xfer_page       = 8'd0;
        xfer_pos        = 9'd0;
        cyc_bank        = 9'd0;
        page_readback   = PAGE_RST;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_status();
        test_start_delay();
        test_full_transfer();
        test_restart();
        test_random_traffic(75);
        test_full_rate();

        // drain, the watchdog catches a hang
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);

        $display("covered %0d items, %0d results of which %0d byte copies", items_sent,
                 results_seen, copies_seen);
        $display("sprite window reported blocked on %0d access checks", blocked_seen);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== oam_dma_engine.f =====
rtl/core/oam_pkg.sv
rtl/core/oam_ctrl.sv
rtl/core/oam_dp.sv
rtl/core/oam_dma_engine.sv
tb/tb_oam_dma_engine.sv
